// ----- hdl/sequence_reorder_buffer_core_defines.svh -----
// Assertion macros shared by the reorder buffer RTL.
`ifndef SEQUENCE_REORDER_BUFFER_CORE_DEFINES_SVH
`define SEQUENCE_REORDER_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/srb_pkg.sv -----
package srb_pkg;

	// Field widths
	localparam int SEQ_W  = 64;
	localparam int SRC_W  = 32;
	localparam int TAG_W  = 16;
	localparam int LEN_W  = 16;
	localparam int STAT_W = 3;

	// Defaults and limits
	localparam int WINDOW_DEF = 32;
	localparam int MAX_LEN    = 16384;

	// Index unit: bits of the sequence number consumed per cycle
	localparam int MOD_DIGIT_W = 8;
	localparam int MOD_STEPS   = SEQ_W / MOD_DIGIT_W;

	typedef enum logic [STAT_W-1:0] {
		ST_IN_ORDER  = 3'd0,
		ST_EVICTED   = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_LATE      = 3'd3,
		ST_BAD_LEN   = 3'd4
	} status_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [SRC_W-1:0] src;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
	} rec_t;

	typedef struct packed {
		logic pend;
		rec_t rec;
	} slot_t;

	// Controller to datapath
	typedef struct packed {
		logic    cap_in;
		logic    clr_we;
		logic    rd_ins;
		logic    rd_drain;
		logic    seen_we;
		logic    slot_we_ins;
		logic    slot_we_rel;
		logic    next_inc;
		logic    held_ld_in;
		logic    held_ld_slot;
		status_t held_code;
		logic    out_ld;
		logic    out_last;
	} srb_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic idx_done;
		logic bad_len;
		logic seen_hit;
		logic late;
		logic pend;
		logic same;
		logic drain_hit;
		logic out_free;
	} srb_stat_t;

endpackage

// ----- hdl/srb_if.sv -----
// Input record channel
interface srb_in_if import srb_pkg::*;;
	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] seq;
	logic [SRC_W-1:0] source_id;
	logic [TAG_W-1:0] payload_tag;
	logic [LEN_W-1:0] byte_len;

	modport source (output valid, seq, source_id, payload_tag, byte_len, input ready);
	modport sink (input valid, seq, source_id, payload_tag, byte_len, output ready);
endinterface

// Result channel
interface srb_out_if import srb_pkg::*;;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [SEQ_W-1:0]  out_seq;
	logic [SRC_W-1:0]  out_source_id;
	logic [TAG_W-1:0]  out_tag;
	logic [LEN_W-1:0]  out_len;
	logic              last;

	modport source (output valid, status, out_seq, out_source_id, out_tag, out_len, last,
		input ready);
	modport sink (input valid, status, out_seq, out_source_id, out_tag, out_len, last,
		output ready);
endinterface

// ----- hdl/srb_mod.sv -----
// Slot index unit: seq mod WINDOW.
// Power-of-two window: low bits, ready in the cycle after start.
// Otherwise: restoring reduction, MOD_DIGIT_W bits per cycle over MOD_STEPS steps,
// ready once the last step is registered.
module srb_mod import srb_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [SEQ_W-1:0]           seq,
	output logic                       done,
	output logic [$clog2(WINDOW)-1:0]  idx
);

	localparam int IDX_W = $clog2(WINDOW);
	localparam bit POW2  = (WINDOW & (WINDOW - 1)) == 0;

	generate
		if (POW2) begin : g_pow2
			logic             done_q;
			logic [IDX_W-1:0] idx_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else if (start) begin
					done_q <= 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					idx_q <= seq[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign idx  = idx_q;
		end else begin : g_div
			localparam int CNT_W = $clog2(MOD_STEPS);

			logic             busy_q;
			logic             done_q;
			logic [CNT_W-1:0] cnt_q;
			logic [SEQ_W-1:0] sh_q;
			logic [IDX_W-1:0] rem_q;
			logic [IDX_W-1:0] rem_d;

			// One digit of restoring reduction, MSB first
			always_comb begin
				logic [IDX_W:0]   t;
				logic [IDX_W-1:0] r;
				r = rem_q;
				t = '0;
				for (int i = 0; i < MOD_DIGIT_W; i++) begin
					t = {r, sh_q[SEQ_W-1-i]};
					if (t >= (IDX_W+1)'(WINDOW)) begin
						t = t - (IDX_W+1)'(WINDOW);
					end
					r = t[IDX_W-1:0];
				end
				rem_d = r;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else if (start) begin
					busy_q <= 1'b1;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= seq;
					rem_q <= '0;
				end else if (busy_q) begin
					sh_q  <= sh_q << MOD_DIGIT_W;
					rem_q <= rem_d;
				end
			end

			assign done = done_q;
			assign idx  = rem_q;
		end
	endgenerate

endmodule

// ----- hdl/srb_dp.sv -----
`include "sequence_reorder_buffer_core_defines.svh"

// Datapath: input register, slot and seen memories, expected counter,
// held result and output register.
module srb_dp import srb_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srb_cmd_t          cmd,
	output srb_stat_t         stat,
	input  logic [SEQ_W-1:0]  in_seq,
	input  logic [SRC_W-1:0]  in_source_id,
	input  logic [TAG_W-1:0]  in_tag,
	input  logic [LEN_W-1:0]  in_len,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] out_status,
	output logic [SEQ_W-1:0]  out_seq,
	output logic [SRC_W-1:0]  out_source_id,
	output logic [TAG_W-1:0]  out_tag,
	output logic [LEN_W-1:0]  out_len,
	output logic              out_last
);

	localparam int IDX_W = $clog2(WINDOW);

	rec_t             in_q;
	logic             idx_done;
	logic [IDX_W-1:0] ins_idx;
	logic [IDX_W-1:0] clr_idx_q;
	logic [SEQ_W-1:0] next_q;
	logic [IDX_W-1:0] next_idx_q;

	slot_t            slot_mem [WINDOW];
	logic [SEQ_W-1:0] seen_mem [WINDOW];
	slot_t            slot_rd_q;
	logic [SEQ_W-1:0] seen_rd_q;

	logic             slot_we;
	logic [IDX_W-1:0] slot_wa;
	slot_t            slot_wd;
	logic             seen_we;
	logic [IDX_W-1:0] seen_wa;
	logic [SEQ_W-1:0] seen_wd;
	logic             rd_en;
	logic [IDX_W-1:0] rd_a;

	rec_t             held_q;
	status_t          held_st_q;
	logic             out_vld_q;
	rec_t             out_q;
	status_t          out_st_q;
	logic             out_last_q;

	// Input capture
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			in_q <= '{seq: in_seq, src: in_source_id, tag: in_tag, len: in_len};
		end
	end

	srb_mod #(.WINDOW(WINDOW)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cap_in),
		.seq    (in_seq),
		.done   (idx_done),
		.idx    (ins_idx)
	);

	// Clearing pass counter and expected sequence number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			next_q     <= '0;
			next_idx_q <= '0;
		end else begin
			if (cmd.clr_we) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (cmd.next_inc) begin
				next_q <= next_q + SEQ_W'(1);
				// index tracks next_q mod WINDOW, also across the 64-bit wrap
				if (next_q == '1 || next_idx_q == IDX_W'(WINDOW - 1)) begin
					next_idx_q <= '0;
				end else begin
					next_idx_q <= next_idx_q + IDX_W'(1);
				end
			end
		end
	end

	// Memory port muxing
	always_comb begin
		slot_we = cmd.clr_we | cmd.slot_we_ins | cmd.slot_we_rel;
		slot_wa = next_idx_q;
		slot_wd = '{pend: 1'b0, rec: slot_rd_q.rec};
		if (cmd.clr_we) begin
			slot_wa = clr_idx_q;
			slot_wd = '0;
		end else if (cmd.slot_we_ins) begin
			slot_wa = ins_idx;
			slot_wd = '{pend: 1'b1, rec: in_q};
		end
		seen_we = cmd.clr_we | cmd.seen_we;
		seen_wa = cmd.clr_we ? clr_idx_q : ins_idx;
		seen_wd = cmd.clr_we ? '1 : in_q.seq;
		rd_en   = cmd.rd_ins | cmd.rd_drain;
		rd_a    = cmd.rd_drain ? next_idx_q : ins_idx;
	end

	// Slot and seen memories, registered reads
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (seen_we) begin
			seen_mem[seen_wa] <= seen_wd;
		end
		if (rd_en) begin
			slot_rd_q <= slot_mem[rd_a];
		end
		if (cmd.rd_ins) begin
			seen_rd_q <= seen_mem[ins_idx];
		end
	end

	// Status to the controller
	always_comb begin
		stat.clr_last  = clr_idx_q == IDX_W'(WINDOW - 1);
		stat.idx_done  = idx_done;
		stat.bad_len   = in_q.len == '0 || in_q.len > LEN_W'(MAX_LEN);
		stat.seen_hit  = seen_rd_q == in_q.seq;
		stat.late      = in_q.seq < next_q;
		stat.pend      = slot_rd_q.pend;
		stat.same      = slot_rd_q.rec.seq == in_q.seq;
		stat.drain_hit = slot_rd_q.pend && slot_rd_q.rec.seq == next_q;
		stat.out_free  = !out_vld_q || out_ready;
	end

	// Held result: waits until it is known whether it is the last one
	always_ff @(posedge clk) begin
		if (cmd.held_ld_in) begin
			held_q    <= in_q;
			held_st_q <= cmd.held_code;
		end else if (cmd.held_ld_slot) begin
			held_q    <= slot_rd_q.rec;
			held_st_q <= cmd.held_code;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_q      <= held_q;
			out_st_q   <= held_st_q;
			out_last_q <= cmd.out_last;
		end
	end

	assign out_valid     = out_vld_q;
	assign out_status    = out_st_q;
	assign out_seq       = out_q.seq;
	assign out_source_id = out_q.src;
	assign out_tag       = out_q.tag;
	assign out_len       = out_q.len;
	assign out_last      = out_last_q;

	// Checks
	`SRB_ASSERT_IMP(a_out_no_overwrite, clk, arst_n, cmd.out_ld, stat.out_free, "result overwritten before transfer")
	`SRB_ASSERT_NXT(a_next_step, clk, arst_n, cmd.next_inc, next_q == $past(next_q) + SEQ_W'(1), "expected seq did not advance")
	`SRB_ASSERT_IMP(a_idx_range, clk, arst_n, cmd.rd_ins, ins_idx <= IDX_W'(WINDOW - 1), "slot index out of window")

endmodule

// ----- hdl/srb_ctrl.sv -----
`include "sequence_reorder_buffer_core_defines.svh"

// Controller: clearing pass, per-record check sequence, drain walk.
module srb_ctrl import srb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  srb_stat_t stat,
	output srb_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_CLEAR     = 7'b0000001,
		S_IDLE      = 7'b0000010,
		S_INDEX     = 7'b0000100,
		S_CHECK     = 7'b0001000,
		S_DRAIN_RD  = 7'b0010000,
		S_DRAIN_CHK = 7'b0100000,
		S_FLUSH     = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   held_vld_q;
	logic   held_vld_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			held_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			held_vld_q <= held_vld_d;
		end
	end

	// Next state and commands
	always_comb begin
		cmd        = '0;
		cmd.held_code = ST_IN_ORDER;
		state_d    = state_q;
		held_vld_d = held_vld_q;
		in_ready   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = S_INDEX;
				end
			end
			S_INDEX: begin
				if (stat.idx_done) begin
					cmd.rd_ins = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.bad_len) begin
					cmd.held_ld_in = 1'b1;
					cmd.held_code  = ST_BAD_LEN;
					held_vld_d     = 1'b1;
					state_d        = S_FLUSH;
				end else if (stat.seen_hit) begin
					cmd.held_ld_in = 1'b1;
					cmd.held_code  = ST_DUPLICATE;
					held_vld_d     = 1'b1;
					state_d        = S_FLUSH;
				end else begin
					cmd.seen_we = 1'b1;
					if (stat.late) begin
						cmd.held_ld_in = 1'b1;
						cmd.held_code  = ST_LATE;
						held_vld_d     = 1'b1;
						state_d        = S_FLUSH;
					end else if (stat.pend && stat.same) begin
						// same seq still pending in its slot
						cmd.held_ld_in = 1'b1;
						cmd.held_code  = ST_DUPLICATE;
						held_vld_d     = 1'b1;
						state_d        = S_FLUSH;
					end else begin
						cmd.slot_we_ins = 1'b1;
						if (stat.pend) begin
							cmd.held_ld_slot = 1'b1;
							cmd.held_code    = ST_EVICTED;
							held_vld_d       = 1'b1;
						end
						state_d = S_DRAIN_RD;
					end
				end
			end
			S_DRAIN_RD: begin
				cmd.rd_drain = 1'b1;
				state_d      = S_DRAIN_CHK;
			end
			S_DRAIN_CHK: begin
				if (stat.drain_hit) begin
					// another result follows: push the held one out first
					if (!held_vld_q || stat.out_free) begin
						cmd.out_ld       = held_vld_q;
						cmd.held_ld_slot = 1'b1;
						cmd.held_code    = ST_IN_ORDER;
						cmd.slot_we_rel  = 1'b1;
						cmd.next_inc     = 1'b1;
						held_vld_d       = 1'b1;
						state_d          = S_DRAIN_RD;
					end
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!held_vld_q) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_last = 1'b1;
					held_vld_d   = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Checks
	`SRB_ASSERT_IMP(a_check_held_empty, clk, arst_n, state_q == S_CHECK, !held_vld_q, "held result left over from previous record")
	`SRB_ASSERT_IMP(a_held_not_lost, clk, arst_n, cmd.held_ld_slot && held_vld_q, cmd.out_ld, "held result dropped")
	`SRB_ASSERT_IMP(a_accept_clean, clk, arst_n, in_ready, !held_vld_q, "record accepted with a result still held")

endmodule

// ----- hdl/sequence_reorder_buffer_core.sv -----
// Sequence-number reorder buffer, one record at a time.
// Rejected record: accept, index, check, flush, then ready again. Stored record: accept, index,
// check, then a drain read and check per in-order release and a last read, check and flush.
// A non-power-of-two WINDOW slows the index step; output stalls hold the drain walk.
// Reset: arst_n clears control; a clearing pass over all WINDOW slots runs before ingress.ready.
module sequence_reorder_buffer_core import srb_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	srb_in_if.sink    ingress,
	srb_out_if.source egress
);

	srb_cmd_t  cmd;
	srb_stat_t stat;

	srb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ingress.valid),
		.in_ready (ingress.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srb_dp #(.WINDOW(WINDOW)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_seq        (ingress.seq),
		.in_source_id  (ingress.source_id),
		.in_tag        (ingress.payload_tag),
		.in_len        (ingress.byte_len),
		.out_valid     (egress.valid),
		.out_ready     (egress.ready),
		.out_status    (egress.status),
		.out_seq       (egress.out_seq),
		.out_source_id (egress.out_source_id),
		.out_tag       (egress.out_tag),
		.out_len       (egress.out_len),
		.out_last      (egress.last)
	);

endmodule

// ----- bench/tb_sequence_reorder_buffer_core.sv -----
module tb_sequence_reorder_buffer_core;
	import srb_pkg::*;

	localparam int WINDOW      = WINDOW_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 120;
	localparam int RANDOM_RECS = 180;
	localparam int PRINT_CAP   = 40;

	// One result the block owes us
	typedef struct {
		status_t          stat;
		logic [SEQ_W-1:0] seq;
		logic [SRC_W-1:0] src;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
		logic             last;
	} release_t;

	// Receiver back-pressure styles
	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_PERIODIC,
		RDY_SPARSE
	} ready_mode_t;

	logic clk;
	logic arst_n;

	srb_in_if  in_ch ();
	srb_out_if out_ch ();

	sequence_reorder_buffer_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ingress (in_ch),
		.egress  (out_ch)
	);

	// Reorder window mirror
	logic             slot_held    [WINDOW];
	rec_t             slot_rec     [WINDOW];
	logic [SEQ_W-1:0] seen_at_slot [WINDOW];
	logic [SEQ_W-1:0] expect_next;

	rec_t     records_to_send [$];
	release_t releases_due    [$];

	int unsigned queued_count;
	int unsigned accepted_count;
	int unsigned results_seen;
	int unsigned mismatches;
	int unsigned idle_cycles;
	int unsigned widest_burst;
	int unsigned status_hits [5];
	logic        in_taken;

	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned stall_cycle;
	ready_mode_t stall_mode;

	// Clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
	endtask

	function automatic release_t make_release(input status_t st, input rec_t r);
		release_t o;
		o.stat = st;
		o.seq  = r.seq;
		o.src  = r.src;
		o.tag  = r.tag;
		o.len  = r.len;
		o.last = 1'b0;
		return o;
	endfunction

	// Work out the results one accepted record causes
	task automatic reorder_predict(input rec_t r);
		int unsigned idx;
		int unsigned j;
		release_t burst [$];
		idx = int'(r.seq % WINDOW);
		if (r.len == '0 || r.len > MAX_LEN) begin
			burst.push_back(make_release(ST_BAD_LEN, r));
		end else if (seen_at_slot[idx] == r.seq) begin
			burst.push_back(make_release(ST_DUPLICATE, r));
		end else begin
			seen_at_slot[idx] = r.seq;
			if (r.seq < expect_next) begin
				burst.push_back(make_release(ST_LATE, r));
			end else if (slot_held[idx] && slot_rec[idx].seq == r.seq) begin
				burst.push_back(make_release(ST_DUPLICATE, r));
			end else begin
				// a different record in the slot leaves early
				if (slot_held[idx])
					burst.push_back(make_release(ST_EVICTED, slot_rec[idx]));
				slot_rec[idx]  = r;
				slot_held[idx] = 1'b1;
				// release the in-order run
				j = int'(expect_next % WINDOW);
				while (slot_held[j] && slot_rec[j].seq == expect_next) begin
					burst.push_back(make_release(ST_IN_ORDER, slot_rec[j]));
					slot_held[j] = 1'b0;
					expect_next++;
					j = int'(expect_next % WINDOW);
				end
			end
		end
		if (burst.size() > 0)
			burst[burst.size()-1].last = 1'b1;
		if (burst.size() > widest_burst)
			widest_burst = burst.size();
		foreach (burst[k])
			releases_due.push_back(burst[k]);
	endtask

	task automatic push_record(input logic [SEQ_W-1:0] seq, input logic [SRC_W-1:0] src,
			input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
		rec_t r;
		r.seq = seq;
		r.src = src;
		r.tag = tag;
		r.len = len;
		records_to_send.push_back(r);
		queued_count++;
	endtask

	function automatic logic [LEN_W-1:0] rand_len();
		case ($urandom_range(0, 9))
			0: return 16'd1;
			1: return 16'(MAX_LEN);
			default: return 16'($urandom_range(1, MAX_LEN));
		endcase
	endfunction

	task automatic shuffle_seqs(ref logic [SEQ_W-1:0] q [$]);
		int unsigned j;
		logic [SEQ_W-1:0] t;
		for (int i = q.size() - 1; i > 0; i--) begin
			j    = $urandom_range(0, i);
			t    = q[i];
			q[i] = q[j];
			q[j] = t;
		end
	endtask

	// Hold until every queued record went in and every result came out
	task automatic wait_drained();
		@(negedge clk);
		while (accepted_count != queued_count || releases_due.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Sender: bursts of transfers with random gaps
	always @(negedge clk) begin : drive_records
		rec_t r;
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				in_taken = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (records_to_send.size() > 0) begin
					r = records_to_send.pop_front();
					in_ch.valid       <= 1'b1;
					in_ch.seq         <= r.seq;
					in_ch.source_id   <= r.src;
					in_ch.payload_tag <= r.tag;
					in_ch.byte_len    <= r.len;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern switches periodically to a randomly picked ready mode
	always @(negedge clk) begin
		stall_cycle++;
		if (stall_cycle % 64 == 0)
			stall_mode = ready_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			RDY_ALWAYS:   out_ch.ready <= 1'b1;
			RDY_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
			RDY_PERIODIC: out_ch.ready <= (stall_cycle % 4) != 0;
			default:      out_ch.ready <= (stall_cycle % 16) < 3;
		endcase
	end

	// Monitor both channels
	always @(posedge clk) begin : watch_channels
		release_t want;
		rec_t     got_in;
		logic     moved;
		moved = 1'b0;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			moved = 1'b1;
			results_seen++;
			if (out_ch.status < 5)
				status_hits[out_ch.status]++;
			if (releases_due.size() == 0) begin
				report_mismatch("unexpected result, seq", out_ch.out_seq, '0);
			end else begin
				want = releases_due.pop_front();
				if (out_ch.status !== want.stat)
					report_mismatch("status", 64'(out_ch.status), 64'(want.stat));
				if (out_ch.out_seq !== want.seq)
					report_mismatch("out_seq", out_ch.out_seq, want.seq);
				if (out_ch.out_source_id !== want.src)
					report_mismatch("out_source_id", 64'(out_ch.out_source_id), 64'(want.src));
				if (out_ch.out_tag !== want.tag)
					report_mismatch("out_tag", 64'(out_ch.out_tag), 64'(want.tag));
				if (out_ch.out_len !== want.len)
					report_mismatch("out_len", 64'(out_ch.out_len), 64'(want.len));
				if (out_ch.last !== want.last)
					report_mismatch("last", 64'(out_ch.last), 64'(want.last));
			end
		end
		if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
			moved      = 1'b1;
			in_taken   = 1'b1;
			got_in.seq = in_ch.seq;
			got_in.src = in_ch.source_id;
			got_in.tag = in_ch.payload_tag;
			got_in.len = in_ch.byte_len;
			accepted_count++;
			reorder_predict(got_in);
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	// Watchdog on cycles without any transfer
	initial begin
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT)
			@(negedge clk);
		$display("tb_sequence_reorder_buffer_core failed");
		$finish;
	end

	// Stimulus and end of run
	initial begin : stimulus
		logic [SEQ_W-1:0] run [$];
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] s;
		int unsigned      n;
		int unsigned      directed_count;

		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.seq         = '0;
		in_ch.source_id   = '0;
		in_ch.payload_tag = '0;
		in_ch.byte_len    = '0;
		out_ch.ready      = 1'b0;
		in_taken          = 1'b0;
		queued_count      = 0;
		accepted_count    = 0;
		results_seen      = 0;
		mismatches        = 0;
		idle_cycles       = 0;
		widest_burst      = 0;
		burst_left        = 1;
		gap_left          = 0;
		stall_cycle       = 0;
		stall_mode        = RDY_ALWAYS;
		expect_next       = '0;
		foreach (status_hits[k])
			status_hits[k] = 0;
		for (int i = 0; i < WINDOW; i++) begin
			slot_held[i]    = 1'b0;
			slot_rec[i]     = '0;
			seen_at_slot[i] = '1;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all-ones seq reads as seen right after reset
		push_record('1, '1, '1, 16'd1);
		// bad lengths
		push_record(64'd0, '0, '0, 16'd0);
		push_record(64'd0, 32'h1, 16'h1, 16'(MAX_LEN + 1));
		push_record(64'd0, '1, '1, 16'hffff);
		// in order, then repeat of a seen seq
		push_record(64'd0, '1, 16'h0000, 16'(MAX_LEN));
		push_record(64'd0, '0, 16'hffff, 16'd1);
		push_record(64'd1, 32'hdead_beef, 16'h1234, 16'd1);
		// stored record, then a late record and a pending copy whose seen entry was overwritten
		push_record(64'd33, 32'h0000_0033, 16'h0033, 16'd100);
		push_record(64'd1, 32'h0000_0001, 16'h0001, 16'd7);
		push_record(64'd33, 32'h1111_1111, 16'h2222, 16'd9);
		// occupied slot eviction, twice
		push_record(64'd34, 32'h0000_0034, 16'h0034, 16'd34);
		push_record(64'd66, 32'h0000_0066, 16'h0066, 16'd66);
		push_record(64'd2, 32'h0000_0002, 16'h0002, 16'd2);
		// out-of-order run that drains in one go
		push_record(64'd5, 32'h5, 16'h5, 16'd5);
		push_record(64'd6, 32'h6, 16'h6, 16'd6);
		push_record(64'd4, 32'h4, 16'h4, 16'd4);
		push_record(64'd3, 32'h3, 16'h3, 16'd3);
		// top of the seq range stored and evicted
		push_record(64'd63, 32'h63, 16'h63, 16'd63);
		push_record('1, 32'h8000_0000, 16'h8000, 16'd200);
		push_record(64'd31, '1, '1, 16'(MAX_LEN));
		directed_count = queued_count;
		wait_drained();

		// Random batches, each drained before the next is built
		while (queued_count - directed_count < RANDOM_RECS) begin
			base = expect_next;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					// shuffled run from the next expected seq, with some noise
					n = ($urandom_range(0, 7) == 0) ? WINDOW : $urandom_range(1, 12);
					run.delete();
					for (int i = 0; i < n; i++)
						run.push_back(base + i);
					shuffle_seqs(run);
					foreach (run[i]) begin
						if ($urandom_range(0, 9) == 0) begin
							case ($urandom_range(0, 2))
								0: s = (i > 0) ? run[i-1] : base;
								1: s = (base > 41) ? base - 1 - $urandom_range(0, 40) : base;
								default: s = run[i];
							endcase
							push_record(s, $urandom, 16'($urandom),
								($urandom_range(0, 1) == 0) ? rand_len() :
								($urandom_range(0, 1) == 0) ? 16'd0 :
								16'($urandom_range(MAX_LEN + 1, 65535)));
						end
						push_record(run[i], $urandom, 16'($urandom), rand_len());
					end
				end
				6, 7: begin
					// full window behind a stale record: one eviction plus a whole drain
					push_record(base + 64'(WINDOW) * $urandom_range(1, 1000), $urandom,
						16'($urandom), rand_len());
					run.delete();
					for (int i = 1; i < WINDOW; i++)
						run.push_back(base + i);
					shuffle_seqs(run);
					foreach (run[i])
						push_record(run[i], $urandom, 16'($urandom), rand_len());
					push_record(base, $urandom, 16'($urandom), rand_len());
				end
				default: begin
					// noise: wild seqs, near seqs, late seqs, any length
					n = $urandom_range(4, 10);
					for (int i = 0; i < n; i++) begin
						case ($urandom_range(0, 2))
							0: s = {$urandom, $urandom};
							1: s = base + $urandom_range(0, 3 * WINDOW);
							default: s = (base >= 8) ? base - $urandom_range(1, 8) : base;
						endcase
						push_record(s, $urandom, 16'($urandom),
							($urandom_range(0, 2) == 0) ? 16'($urandom) : rand_len());
					end
				end
			endcase
			wait_drained();
		end

		// Let the block settle, then look for anything left over
		repeat (DRAIN_WAIT) @(posedge clk);
		while (releases_due.size() != 0) begin
			report_mismatch("result never came, seq", '0, releases_due[0].seq);
			void'(releases_due.pop_front());
		end

		$display("run: %0d records in, %0d results out, up to %0d results from one record",
			accepted_count, results_seen, widest_burst);
		$display("by status: in order %0d, evicted %0d, duplicate %0d, late %0d, bad length %0d",
			status_hits[ST_IN_ORDER], status_hits[ST_EVICTED], status_hits[ST_DUPLICATE],
			status_hits[ST_LATE], status_hits[ST_BAD_LEN]);
		if (mismatches == 0)
			$display("tb_sequence_reorder_buffer_core passed");
		else
			$display("tb_sequence_reorder_buffer_core failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/srb_pkg.sv
hdl/srb_if.sv
hdl/srb_mod.sv
hdl/srb_dp.sv
hdl/srb_ctrl.sv
hdl/sequence_reorder_buffer_core.sv
bench/tb_sequence_reorder_buffer_core.sv
